### src/agd_pkg.sv
// ----------------------------------------------------------------------------
// agd_pkg
// Types and constants shared by the adagrad update block and its pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package agd_pkg;

    localparam int unsigned AGD_PARAM_COUNT = 4096;

    localparam int unsigned IDX_W  = 12;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned EPS_W  = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BASE_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON    = 2'd2;

    // input actions
    localparam logic ACTION_GRADIENT = 1'b0;
    localparam logic ACTION_BATCH    = 1'b1;

    localparam logic [DATA_W-1:0] BASE_RATE_RESET  = 32'd167772;
    localparam logic [DATA_W-1:0] DECAY_RATE_RESET = 32'd0;
    localparam logic [EPS_W-1:0]  EPSILON_RESET    = 16'd2;

    typedef struct packed {
        logic                     action;
        logic [IDX_W-1:0]         param_index;
        logic signed [DATA_W-1:0] gradient;
    } agd_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]         echo_index;
        logic signed [DATA_W-1:0] delta;
        logic                     saturated;
    } agd_out_t;

    // one gradient handed to the update pipeline
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] mag;
        logic              neg;
        logic [DATA_W-1:0] rate;
    } agd_push_t;

    typedef struct packed {
        logic clearing;
        logic advance;
    } agd_pipe_status_t;

endpackage

`default_nettype wire

### src/agd_update_pipe.sv
// ----------------------------------------------------------------------------
// agd_update_pipe
// Sum-of-squares store, pipelined integer square root and pipelined divider
// that turn one gradient per cycle, while the output is not stalled, into a saturated weight change.
// ----------------------------------------------------------------------------
`default_nettype none

module agd_update_pipe
    import agd_pkg::*;
#(
    parameter int unsigned PARAM_COUNT = AGD_PARAM_COUNT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire agd_push_t        push_data,
    input  wire logic [EPS_W-1:0] epsilon_value,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output agd_out_t              out_data,
    output agd_pipe_status_t      status
);

    localparam int unsigned AW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
    localparam int unsigned ROOT_STEPS = 32;
    localparam int unsigned QUOT_STEPS = 32;

    typedef struct packed {
        logic      valid;
        agd_push_t d;
    } p1_t;

    typedef struct packed {
        logic      valid;
        agd_push_t d;
        logic [63:0] sq;
        logic [63:0] old;
    } p2_t;

    typedef struct packed {
        logic        valid;
        logic [IDX_W-1:0] idx;
        logic [63:0] sum;
    } fwd_t;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] mag;
        logic              neg;
        logic [DATA_W-1:0] rate;
        logic              sat;
        logic [32:0]       rem;
        logic [31:0]       root;
        logic [63:0]       v;
    } rt_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             neg;
        logic             sat;
        logic             zero;
        logic [32:0]      den;
        logic [63:0]      num;
    } dv_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             neg;
        logic             sat;
        logic             zero;
        logic             ovf;
        logic [32:0]      rem;
        logic [32:0]      den;
        logic [31:0]      low;
    } qt_t;

    function automatic rt_t rt_step(input rt_t s);
        rt_t         r;
        logic [34:0] rsh;
        logic [34:0] trial;
        r     = s;
        rsh   = {s.rem, s.v[63:62]};
        trial = {1'b0, s.root, 2'b01};
        r.v   = {s.v[61:0], 2'b00};
        if (rsh >= trial)
        begin
            r.rem  = 33'(rsh - trial);
            r.root = {s.root[30:0], 1'b1};
        end
        else
        begin
            r.rem  = rsh[32:0];
            r.root = {s.root[30:0], 1'b0};
        end
        return r;
    endfunction

    function automatic qt_t qt_step(input qt_t s);
        qt_t         r;
        logic [33:0] rsh;
        logic [33:0] dx;
        r   = s;
        rsh = {s.rem, s.low[31]};
        dx  = {1'b0, s.den};
        if (rsh >= dx)
        begin
            r.rem = 33'(rsh - dx);
            r.low = {s.low[30:0], 1'b1};
        end
        else
        begin
            r.rem = rsh[32:0];
            r.low = {s.low[30:0], 1'b0};
        end
        return r;
    endfunction

    logic [63:0] mem [PARAM_COUNT];
    logic [63:0] mem_q_reg;

    logic          clr_active_reg, clr_active_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    p1_t  p1_reg, p1_next;
    p2_t  p2_reg, p2_next;
    fwd_t f1_reg, f1_next, f2_reg, f2_next;
    rt_t  rt_reg [ROOT_STEPS+1];
    rt_t  rt_next [ROOT_STEPS+1];
    dv_t  dv_reg, dv_next;
    qt_t  qt_reg [QUOT_STEPS+1];
    qt_t  qt_next [QUOT_STEPS+1];
    logic     out_valid_reg, out_valid_next;
    agd_out_t out_reg, out_next;

    logic          adv;
    logic [63:0]   old_sum;
    logic [64:0]   sum_wide;
    logic [63:0]   sum_new;
    logic          sum_sat;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [63:0]   mem_wdata;
    logic [AW-1:0] push_addr;
    logic [AW-1:0] p2_addr;
    logic [31:0]   push_idx_ext;
    logic [31:0]   p2_idx_ext;
    logic [31:0]   q_final;

    assign adv = !(out_valid_reg && out_stall);
    assign status.clearing = clr_active_reg;
    assign status.advance  = adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign push_idx_ext = 32'(push_data.idx);
    assign p2_idx_ext   = 32'(p2_reg.d.idx);
    assign push_addr    = push_idx_ext[AW-1:0];
    assign p2_addr      = p2_idx_ext[AW-1:0];

    // clearing pass after reset
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_cnt_next    = clr_cnt_reg;
        if (clr_active_reg)
        begin
            if (32'(clr_cnt_reg) == PARAM_COUNT - 1)
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
    end

    // the read at transfer time misses the writes of the two items ahead
    always_comb
    begin
        if (f1_reg.valid && f1_reg.idx == p2_reg.d.idx)
        begin
            old_sum = f1_reg.sum;
        end
        else if (f2_reg.valid && f2_reg.idx == p2_reg.d.idx)
        begin
            old_sum = f2_reg.sum;
        end
        else
        begin
            old_sum = p2_reg.old;
        end
        sum_wide = {1'b0, old_sum} + {1'b0, p2_reg.sq};
        sum_sat  = sum_wide[64];
        sum_new  = sum_sat ? {64{1'b1}} : sum_wide[63:0];
    end

    always_comb
    begin
        mem_we    = clr_active_reg || (adv && p2_reg.valid);
        mem_waddr = clr_active_reg ? clr_cnt_reg : p2_addr;
        mem_wdata = clr_active_reg ? 64'd0 : sum_new;
    end

    always_comb
    begin
        p1_next.valid = push;
        p1_next.d     = push_data;

        p2_next.valid = p1_reg.valid;
        p2_next.d     = p1_reg.d;
        p2_next.sq    = 64'(p1_reg.d.mag) * 64'(p1_reg.d.mag);
        p2_next.old   = mem_q_reg;

        f1_next.valid = p2_reg.valid;
        f1_next.idx   = p2_reg.d.idx;
        f1_next.sum   = sum_new;
        f2_next       = f1_reg;

        rt_next[0].valid = p2_reg.valid;
        rt_next[0].idx   = p2_reg.d.idx;
        rt_next[0].mag   = p2_reg.d.mag;
        rt_next[0].neg   = p2_reg.d.neg;
        rt_next[0].rate  = p2_reg.d.rate;
        rt_next[0].sat   = sum_sat;
        rt_next[0].rem   = '0;
        rt_next[0].root  = '0;
        rt_next[0].v     = sum_new;
        for (int j = 0; j < ROOT_STEPS; j++)
        begin
            rt_next[j+1] = rt_step(rt_reg[j]);
        end

        dv_next.valid = rt_reg[ROOT_STEPS].valid;
        dv_next.idx   = rt_reg[ROOT_STEPS].idx;
        dv_next.neg   = rt_reg[ROOT_STEPS].neg;
        dv_next.sat   = rt_reg[ROOT_STEPS].sat;
        dv_next.zero  = (rt_reg[ROOT_STEPS].mag == '0);
        dv_next.den   = 33'(epsilon_value) + 33'(rt_reg[ROOT_STEPS].root);
        dv_next.num   = 64'(rt_reg[ROOT_STEPS].rate) * 64'(rt_reg[ROOT_STEPS].mag);

        qt_next[0].valid = dv_reg.valid;
        qt_next[0].idx   = dv_reg.idx;
        qt_next[0].neg   = dv_reg.neg;
        qt_next[0].sat   = dv_reg.sat;
        qt_next[0].zero  = dv_reg.zero || (dv_reg.den == '0);
        // quotient of 2^32 or more saturates either way
        qt_next[0].ovf   = ({1'b0, dv_reg.num[63:32]} >= dv_reg.den);
        qt_next[0].rem   = {1'b0, dv_reg.num[63:32]};
        qt_next[0].den   = dv_reg.den;
        qt_next[0].low   = dv_reg.num[31:0];
        for (int j = 0; j < QUOT_STEPS; j++)
        begin
            qt_next[j+1] = qt_step(qt_reg[j]);
        end
    end

    always_comb
    begin
        q_final             = qt_reg[QUOT_STEPS].low;
        out_valid_next      = qt_reg[QUOT_STEPS].valid;
        out_next.echo_index = qt_reg[QUOT_STEPS].idx;
        out_next.saturated  = qt_reg[QUOT_STEPS].sat;
        if (qt_reg[QUOT_STEPS].zero)
        begin
            out_next.delta = '0;
        end
        else if (qt_reg[QUOT_STEPS].neg)
        begin
            if (qt_reg[QUOT_STEPS].ovf || q_final > 32'h7fff_ffff)
            begin
                out_next.delta     = 32'sh7fff_ffff;
                out_next.saturated = 1'b1;
            end
            else
            begin
                out_next.delta = signed'(q_final);
            end
        end
        else
        begin
            if (qt_reg[QUOT_STEPS].ovf || q_final > 32'h8000_0000)
            begin
                out_next.delta     = signed'(32'h8000_0000);
                out_next.saturated = 1'b1;
            end
            else
            begin
                out_next.delta = signed'(32'd0 - q_final);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (push)
        begin
            mem_q_reg <= mem[push_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            p1_reg         <= '0;
            p2_reg         <= '0;
            f1_reg         <= '0;
            f2_reg         <= '0;
            dv_reg         <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            for (int j = 0; j <= ROOT_STEPS; j++)
            begin
                rt_reg[j] <= '0;
            end
            for (int j = 0; j <= QUOT_STEPS; j++)
            begin
                qt_reg[j] <= '0;
            end
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_cnt_reg    <= clr_cnt_next;
            if (adv)
            begin
                p1_reg        <= p1_next;
                p2_reg        <= p2_next;
                f1_reg        <= f1_next;
                f2_reg        <= f2_next;
                dv_reg        <= dv_next;
                out_valid_reg <= out_valid_next;
                out_reg       <= out_next;
                for (int j = 0; j <= ROOT_STEPS; j++)
                begin
                    rt_reg[j] <= rt_next[j];
                end
                for (int j = 0; j <= QUOT_STEPS; j++)
                begin
                    qt_reg[j] <= qt_next[j];
                end
            end
        end
    end

    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !out_valid_reg)
        else $error("result presented during clearing pass");

    a_push_only_when_running: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (adv && !clr_active_reg))
        else $error("gradient pushed into a frozen or clearing pipeline");

    a_frozen_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(qt_reg[0]))
        else $error("divider entry stage changed while pipeline frozen");

endmodule

`default_nettype wire

### src/adagrad_parameter_update.sv
// ----------------------------------------------------------------------------
// adagrad_parameter_update
// Fixed-point adagrad step: accumulates squared gradients per parameter and
// emits -rate*g/(epsilon+sqrt(sum)); batch starts update the decayed rate.
// ----------------------------------------------------------------------------
//  channel   signals                      transfer when
//  input     in_valid, in_stall, in_data  in_valid && !in_stall
//  output    out_valid, out_stall, out_data  out_valid && !out_stall
//  config    cfg_we, cfg_index, cfg_wdata    cfg_we
//
//  one gradient per cycle while the input is not stalled; a result passes through
//  a 32-step square root pipeline followed by a 32-step quotient pipeline
//  after reset the sum store is cleared entry by entry, input stalled
//  a batch start with nonzero decay stalls input through the rate update (56-step rate divider)
//  an output stall while out_valid is high freezes the whole pipeline and stalls the input
// ----------------------------------------------------------------------------
`default_nettype none

module adagrad_parameter_update
    import agd_pkg::*;
#(
    parameter int unsigned PARAM_COUNT = AGD_PARAM_COUNT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire agd_in_t              in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output agd_out_t                  out_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_wdata
);

    localparam int unsigned RATE_STEPS = 56;
    localparam logic [63:0] ONE_Q24 = 64'd1 << 24;

    typedef enum logic [2:0] {
        RATE_IDLE = 3'b001,
        RATE_DEN  = 3'b010,
        RATE_DIV  = 3'b100
    } agd_rate_state_t;

    logic [DATA_W-1:0] base_rate_reg, base_rate_next;
    logic [DATA_W-1:0] decay_rate_reg, decay_rate_next;
    logic [EPS_W-1:0]  epsilon_reg, epsilon_next;
    logic [DATA_W-1:0] batch_count_reg, batch_count_next;
    logic [DATA_W-1:0] current_rate_reg, current_rate_next;

    agd_rate_state_t rate_state_reg, rate_state_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] den_reg, den_next;
    logic [63:0] rem_reg, rem_next;
    logic [55:0] num_reg, num_next;
    logic [5:0]  step_reg, step_next;

    agd_pipe_status_t status;
    agd_push_t        push_data;
    logic             push;
    logic             accept;
    logic             batch;
    logic [64:0]      den_wide;
    logic [64:0]      rem_sh;
    logic [31:0]      grad_u;

    assign in_stall = status.clearing || (rate_state_reg != RATE_IDLE) || !status.advance;
    assign accept   = in_valid && !in_stall;
    assign batch    = accept && (in_data.action == ACTION_BATCH);
    assign push     = accept && (in_data.action == ACTION_GRADIENT)
                      && (32'(in_data.param_index) < PARAM_COUNT);

    assign grad_u         = unsigned'(in_data.gradient);
    assign push_data.idx  = in_data.param_index;
    assign push_data.neg  = grad_u[31];
    assign push_data.mag  = grad_u[31] ? (32'd0 - grad_u) : grad_u;
    assign push_data.rate = current_rate_reg;

    always_comb
    begin
        base_rate_next    = base_rate_reg;
        decay_rate_next   = decay_rate_reg;
        epsilon_next      = epsilon_reg;
        batch_count_next  = batch_count_reg;
        current_rate_next = current_rate_reg;
        rate_state_next   = rate_state_reg;
        prod_next         = prod_reg;
        den_next          = den_reg;
        rem_next          = rem_reg;
        num_next          = num_reg;
        step_next         = step_reg;
        den_wide          = {1'b0, prod_reg} + {1'b0, ONE_Q24};
        rem_sh            = {rem_reg, num_reg[55]};

        unique case (rate_state_reg)
            RATE_IDLE:
            begin
                if (batch)
                begin
                    if (batch_count_reg != {DATA_W{1'b1}})
                    begin
                        batch_count_next = batch_count_reg + 1'b1;
                    end
                    if (decay_rate_reg != '0)
                    begin
                        prod_next       = 64'(decay_rate_reg) * 64'(batch_count_reg);
                        rate_state_next = RATE_DEN;
                    end
                end
            end
            RATE_DEN:
            begin
                den_next        = den_wide[64] ? {64{1'b1}} : den_wide[63:0];
                num_next        = {base_rate_reg, 24'd0};
                rem_next        = '0;
                step_next       = '0;
                rate_state_next = RATE_DIV;
            end
            RATE_DIV:
            begin
                // restoring division, quotient bits shift into the numerator
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = 64'(rem_sh - {1'b0, den_reg});
                    num_next = {num_reg[54:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[63:0];
                    num_next = {num_reg[54:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 6'(RATE_STEPS - 1))
                begin
                    current_rate_next = num_next[31:0];
                    rate_state_next   = RATE_IDLE;
                end
            end
            default:
            begin
                rate_state_next = RATE_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE_RATE:
                begin
                    base_rate_next    = cfg_wdata;
                    current_rate_next = cfg_wdata;
                end
                REG_DECAY_RATE:
                begin
                    decay_rate_next = cfg_wdata;
                end
                REG_EPSILON:
                begin
                    epsilon_next = cfg_wdata[EPS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_rate_reg    <= BASE_RATE_RESET;
            decay_rate_reg   <= DECAY_RATE_RESET;
            epsilon_reg      <= EPSILON_RESET;
            batch_count_reg  <= '0;
            current_rate_reg <= BASE_RATE_RESET;
            rate_state_reg   <= RATE_IDLE;
            step_reg         <= '0;
        end
        else
        begin
            base_rate_reg    <= base_rate_next;
            decay_rate_reg   <= decay_rate_next;
            epsilon_reg      <= epsilon_next;
            batch_count_reg  <= batch_count_next;
            current_rate_reg <= current_rate_next;
            rate_state_reg   <= rate_state_next;
            step_reg         <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        num_reg  <= num_next;
    end

    agd_update_pipe #(
        .PARAM_COUNT(PARAM_COUNT)
    ) u_pipe (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .push_data     (push_data),
        .epsilon_value (epsilon_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .status        (status)
    );

    a_rate_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (rate_state_reg != RATE_IDLE) |-> in_stall)
        else $error("input open while rate divider busy");

    a_batch_starts_divider: assert property (@(posedge clk) disable iff (!rst_n)
        (batch && decay_rate_reg != '0) |=> (rate_state_reg == RATE_DEN))
        else $error("batch start with decay did not start rate update");

    a_base_write_loads_rate: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == REG_BASE_RATE) |=> (current_rate_reg == $past(cfg_wdata)))
        else $error("base rate write did not load current rate");

endmodule

`default_nettype wire
